// ----- hw/rtl/lcr_pkg.sv -----
// Shared types, constants and defaults of the learning command router.
package lcr_pkg;

	// Default sizes
	localparam int unsigned NumHostsDef       = 32;
	localparam int unsigned MaxConnectionsDef = 8;
	localparam int unsigned MaxPortsDef       = 15;

	// Register reset values
	localparam logic [7:0]  OwnAddressRst      = 8'd1;
	localparam logic [7:0]  BroadcastAddrRst   = 8'd255;
	localparam logic [3:0]  ConnectionCountRst = 4'd0;
	localparam logic [15:0] PortPresentRst     = 16'd0;

	// Width of a stored route: local flag over port number or connection index
	localparam int unsigned RouteW = 5;

	typedef enum logic [1:0] {
		ST_ROUTED  = 2'd0,
		ST_RETRY   = 2'd1,
		ST_MISSING = 2'd2
	} route_status_t;

	typedef struct packed {
		logic [7:0]  own_address;
		logic [7:0]  broadcast_address;
		logic [3:0]  connection_count;
		logic [15:0] port_present_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0]    conn_mask;
		logic [3:0]    local_target;
		route_status_t route_status;
		logic          learned;
	} route_res_t;

endpackage

// ----- hw/rtl/lcr_regs.sv -----
// APB configuration registers of the learning command router.
module lcr_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output lcr_pkg::cfg_t      cfg
);

	localparam logic [1:0] RegOwn       = 2'd0;
	localparam logic [1:0] RegBroadcast = 2'd1;
	localparam logic [1:0] RegConnCount = 2'd2;
	localparam logic [1:0] RegPortMask  = 2'd3;

	lcr_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Write a register on the access phase of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address       <= lcr_pkg::OwnAddressRst;
			cfg_q.broadcast_address <= lcr_pkg::BroadcastAddrRst;
			cfg_q.connection_count  <= lcr_pkg::ConnectionCountRst;
			cfg_q.port_present_mask <= lcr_pkg::PortPresentRst;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				RegOwn:       cfg_q.own_address       <= pwdata[7:0];
				RegBroadcast: cfg_q.broadcast_address <= pwdata[7:0];
				RegConnCount: cfg_q.connection_count  <= pwdata[3:0];
				RegPortMask:  cfg_q.port_present_mask <= pwdata[15:0];
				default:      cfg_q.own_address       <= cfg_q.own_address;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (paddr[3:2])
			RegOwn:       prdata = {24'd0, cfg_q.own_address};
			RegBroadcast: prdata = {24'd0, cfg_q.broadcast_address};
			RegConnCount: prdata = {28'd0, cfg_q.connection_count};
			RegPortMask:  prdata = {16'd0, cfg_q.port_present_mask};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

// ----- hw/rtl/lcr_table.sv -----
// Per-host route table: valid flags in flip-flops, targets in a memory with bypass.
module lcr_table #(
	parameter int unsigned NUM_HOSTS = lcr_pkg::NumHostsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [$clog2(NUM_HOSTS)-1:0]   rd_idx,
	output logic [lcr_pkg::RouteW-1:0]     rd_data,
	input  logic                           wr_en,
	input  logic [$clog2(NUM_HOSTS)-1:0]   wr_idx,
	input  logic [lcr_pkg::RouteW-1:0]     wr_data,
	input  logic [$clog2(NUM_HOSTS)-1:0]   src_idx,
	input  logic [$clog2(NUM_HOSTS)-1:0]   dst_idx,
	output logic                           src_valid,
	output logic                           dst_valid
);

	logic [NUM_HOSTS-1:0]       valid_q;
	logic [lcr_pkg::RouteW-1:0] tgt_mem [NUM_HOSTS];
	logic [lcr_pkg::RouteW-1:0] mem_q;
	logic [lcr_pkg::RouteW-1:0] fwd_q;
	logic                       fwd_hit_q;

	// Set a valid flag when an entry is learned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	assign src_valid = valid_q[src_idx];
	assign dst_valid = valid_q[dst_idx];

	// Target memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tgt_mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= tgt_mem[rd_idx];
		end
	end

	// Capture a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (wr_idx == rd_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_q <= wr_data;
		end
	end

	assign rd_data = fwd_hit_q ? fwd_q : mem_q;

	// A learned entry is valid from the next cycle on
	a_learn_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(wr_idx)])
		else $error("learned entry not marked valid");

	// A read colliding with a write returns the new data
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en && (wr_idx == rd_idx)) |=> (rd_data == $past(wr_data)))
		else $error("read during write returned stale target");

	// Never write over an entry that is already learned
	a_no_relearn: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (wr_idx == src_idx)) |-> !src_valid)
		else $error("valid entry learned again");

endmodule

// ----- hw/rtl/lcr_decide.sv -----
// Learning decision and target selection for the command held in the input stage.
module lcr_decide #(
	parameter int unsigned NUM_HOSTS       = lcr_pkg::NumHostsDef,
	parameter int unsigned MAX_CONNECTIONS = lcr_pkg::MaxConnectionsDef,
	parameter int unsigned MAX_PORTS       = lcr_pkg::MaxPortsDef
) (
	input  lcr_pkg::cfg_t                  cfg,
	input  logic [7:0]                     src_addr,
	input  logic [7:0]                     dest_addr,
	input  logic [3:0]                     dest_port,
	input  logic                           from_local,
	input  logic [3:0]                     from_index,
	input  logic [7:0]                     conn_full_mask,
	input  logic [15:0]                    local_full_mask,
	output logic [$clog2(NUM_HOSTS)-1:0]   src_idx,
	output logic [$clog2(NUM_HOSTS)-1:0]   dst_idx,
	input  logic                           src_valid,
	input  logic                           dst_valid,
	input  logic [lcr_pkg::RouteW-1:0]     rd_data,
	output lcr_pkg::route_res_t            res
);

	localparam int unsigned HidxW    = $clog2(NUM_HOSTS);
	localparam logic [7:0]  HostsTop = 8'(NUM_HOSTS);
	localparam logic [3:0]  ConnMax  = 4'(MAX_CONNECTIONS);
	localparam logic [3:0]  PortMax  = 4'(MAX_PORTS);

	logic [3:0]                 nconn;
	logic                       src_in;
	logic                       dst_in;
	logic                       arrival_ok;
	logic                       learn;
	logic                       self_hit;
	logic                       route_hit;
	logic [lcr_pkg::RouteW-1:0] route;
	logic                       local_req;
	logic                       missing;
	logic                       full;
	logic [7:0]                 cmask;
	logic [3:0]                 ltarget;

	assign nconn = (cfg.connection_count > ConnMax) ? ConnMax : cfg.connection_count;

	// Host h lives in entry h-1
	assign src_in  = (src_addr != 8'd0) && (src_addr <= HostsTop);
	assign dst_in  = (dest_addr != 8'd0) && (dest_addr <= HostsTop);
	assign src_idx = HidxW'(src_addr - 8'd1);
	assign dst_idx = HidxW'(dest_addr - 8'd1);

	// Learn an unknown source seen at a valid arrival point
	assign arrival_ok = from_local ? ((from_index != 4'd0) && (from_index <= PortMax))
	                               : (from_index < nconn);
	assign learn = src_in && (src_addr != cfg.own_address) && !src_valid && arrival_ok;

	// Learning by this command is visible to its own routing
	assign self_hit  = learn && (src_addr == dest_addr);
	assign route_hit = dst_in && (dest_addr != cfg.broadcast_address) && (dst_valid || self_hit);
	assign route     = self_hit ? {from_local, from_index} : rd_data;
	assign local_req = (dest_port != 4'd0) && ((dest_addr == cfg.own_address) ||
	                   ((dest_addr == cfg.broadcast_address) && (src_addr != cfg.own_address)));

	// Select connection targets, then local delivery
	always_comb begin
		cmask   = 8'd0;
		ltarget = 4'd0;
		missing = 1'b0;
		if (dest_addr != cfg.own_address) begin
			if (route_hit) begin
				if (route[4]) begin
					ltarget = route[3:0];
				end else if (route[3:0] < ConnMax) begin
					cmask = 8'd1 << route[2:0];
				end
			end else begin
				for (int i = 0; i < 8; i++) begin
					cmask[i] = (4'(i) < nconn) && !(!from_local && (from_index == 4'(i)));
				end
			end
		end
		if (local_req) begin
			if ((dest_port <= PortMax) && cfg.port_present_mask[dest_port]) begin
				ltarget = dest_port;
			end else begin
				missing = 1'b1;
			end
		end
	end

	assign full = ((cmask & conn_full_mask) != 8'd0) ||
	              ((ltarget != 4'd0) && local_full_mask[ltarget]);

	// Full queue takes priority over a missing port
	always_comb begin
		res.conn_mask    = cmask;
		res.local_target = ltarget;
		res.learned      = learn;
		priority if (full) begin
			res.route_status = lcr_pkg::ST_RETRY;
		end else if (missing) begin
			res.route_status = lcr_pkg::ST_MISSING;
		end else begin
			res.route_status = lcr_pkg::ST_ROUTED;
		end
	end

endmodule

// ----- hw/rtl/learning_command_router_top.sv -----
// Learning command router: input stage, route table, decision logic and result register.
//
// Accepts one command header per clock cycle. The header and the route table read are
// registered as a command is accepted, and the decision is registered into the result
// stage as the command leaves the input stage. The per-host route table is written when
// a command leaves the input stage, and a target written in that cycle is bypassed to
// the command entering behind it, so a host learned by one command is routed by the
// very next. Valid flags reset to empty at once; no clearing pass is needed. The input
// is held off only while the result register is full and not taken.
module learning_command_router_top #(
	parameter int unsigned NUM_HOSTS       = lcr_pkg::NumHostsDef,
	parameter int unsigned MAX_CONNECTIONS = lcr_pkg::MaxConnectionsDef,
	parameter int unsigned MAX_PORTS       = lcr_pkg::MaxPortsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_addr,
	input  logic [7:0]  dest_addr,
	input  logic [3:0]  dest_port,
	input  logic        from_local,
	input  logic [3:0]  from_index,
	input  logic [7:0]  conn_full_mask,
	input  logic [15:0] local_full_mask,
	// route result
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  conn_mask,
	output logic [3:0]  local_target,
	output logic [1:0]  route_status,
	output logic        learned
);

	localparam int unsigned HidxW    = $clog2(NUM_HOSTS);
	localparam logic [7:0]  HostsTop = 8'(NUM_HOSTS);

	lcr_pkg::cfg_t              cfg;
	lcr_pkg::route_res_t        res;

	logic                       valid_s1;
	logic [7:0]                 src_addr_s1;
	logic [7:0]                 dest_addr_s1;
	logic [3:0]                 dest_port_s1;
	logic                       from_local_s1;
	logic [3:0]                 from_index_s1;
	logic [7:0]                 conn_full_s1;
	logic [15:0]                local_full_s1;

	logic                       out_valid_q;
	logic [7:0]                 conn_mask_q;
	logic [3:0]                 local_target_q;
	logic [1:0]                 route_status_q;
	logic                       learned_q;

	logic                       adv_s1;
	logic                       in_fire;
	logic                       rd_en;
	logic [HidxW-1:0]           rd_idx;
	logic [lcr_pkg::RouteW-1:0] rd_data;
	logic                       wr_en;
	logic [HidxW-1:0]           src_idx;
	logic [HidxW-1:0]           dst_idx;
	logic                       src_valid;
	logic                       dst_valid;

	lcr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the input stage when the result register is free or being emptied
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_fire  = in_valid && in_ready;

	// Read the destination's route as the command enters
	assign rd_en  = in_fire && (dest_addr != 8'd0) && (dest_addr <= HostsTop);
	assign rd_idx = HidxW'(dest_addr - 8'd1);

	// Commit learning once, as the command leaves the input stage
	assign wr_en = adv_s1 && res.learned;

	lcr_table #(
		.NUM_HOSTS (NUM_HOSTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_idx    (src_idx),
		.wr_data   ({from_local_s1, from_index_s1}),
		.src_idx   (src_idx),
		.dst_idx   (dst_idx),
		.src_valid (src_valid),
		.dst_valid (dst_valid)
	);

	lcr_decide #(
		.NUM_HOSTS       (NUM_HOSTS),
		.MAX_CONNECTIONS (MAX_CONNECTIONS),
		.MAX_PORTS       (MAX_PORTS)
	) u_decide (
		.cfg             (cfg),
		.src_addr        (src_addr_s1),
		.dest_addr       (dest_addr_s1),
		.dest_port       (dest_port_s1),
		.from_local      (from_local_s1),
		.from_index      (from_index_s1),
		.conn_full_mask  (conn_full_s1),
		.local_full_mask (local_full_s1),
		.src_idx         (src_idx),
		.dst_idx         (dst_idx),
		.src_valid       (src_valid),
		.dst_valid       (dst_valid),
		.rd_data         (rd_data),
		.res             (res)
	);

	// Input stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the command header
	always_ff @(posedge clk) begin
		if (in_fire) begin
			src_addr_s1   <= src_addr;
			dest_addr_s1  <= dest_addr;
			dest_port_s1  <= dest_port;
			from_local_s1 <= from_local;
			from_index_s1 <= from_index;
			conn_full_s1  <= conn_full_mask;
			local_full_s1 <= local_full_mask;
		end
	end

	// Result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// Register the result transaction
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			conn_mask_q    <= res.conn_mask;
			local_target_q <= res.local_target;
			route_status_q <= res.route_status;
			learned_q      <= res.learned;
		end
	end

	assign out_valid    = out_valid_q;
	assign conn_mask    = conn_mask_q;
	assign local_target = local_target_q;
	assign route_status = route_status_q;
	assign learned      = learned_q;

	// An empty input stage always takes a command
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while stage empty");

	// A command held in the input stage keeps its header
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(src_addr_s1) && $stable(dest_addr_s1)))
		else $error("stalled command lost or changed");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the learning command router.
`timescale 1ns / 100ps

module testbench;

	localparam int NumHosts   = lcr_pkg::NumHostsDef;
	localparam int MaxConn    = lcr_pkg::MaxConnectionsDef;
	localparam int MaxPorts   = lcr_pkg::MaxPortsDef;
	localparam int QuietLimit = 1000;

	typedef enum int {
		REG_OWN_ADDR   = 0,
		REG_BCAST_ADDR = 1,
		REG_CONN_COUNT = 2,
		REG_PORT_MASK  = 3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [3:0]  dport;
		logic        from_loc;
		logic [3:0]  from_idx;
		logic [7:0]  cfull;
		logic [15:0] lfull;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  src_addr = '0;
	logic [7:0]  dest_addr = '0;
	logic [3:0]  dest_port = '0;
	logic        from_local = 1'b0;
	logic [3:0]  from_index = '0;
	logic [7:0]  conn_full_mask = '0;
	logic [15:0] local_full_mask = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  conn_mask;
	logic [3:0]  local_target;
	logic [1:0]  route_status;
	logic        learned;

	// Shadow of the configuration and the per-host route table
	lcr_pkg::cfg_t       shadow;
	logic                host_known [NumHosts];
	logic [4:0]          host_site [NumHosts];

	lcr_pkg::route_res_t route_expect [$];
	int          sender_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatch_count = 0;
	int          commands_sent = 0;
	int          results_seen = 0;
	int          learn_count = 0;
	int          retry_count = 0;
	int          missing_count = 0;
	int          quiet_cycles = 0;

	learning_command_router_top dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Work out the route of one accepted command and update the route table
	task automatic route_command(input cmd_t c, output lcr_pkg::route_res_t r);
		int         nconn;
		logic [4:0] site;
		logic       ok;
		logic       missing;
		logic       full;
		nconn = (shadow.connection_count > MaxConn) ? MaxConn : int'(shadow.connection_count);
		r = '0;
		missing = 1'b0;
		full = 1'b0;
		// learn the arrival point of an unknown source host first
		if (c.src != 0 && c.src <= NumHosts && c.src != shadow.own_address
				&& !host_known[c.src - 1]) begin
			ok = c.from_loc ? (c.from_idx >= 1 && c.from_idx <= MaxPorts)
				: (int'(c.from_idx) < nconn);
			if (ok) begin
				host_known[c.src - 1] = 1'b1;
				host_site[c.src - 1] = {c.from_loc, c.from_idx};
				r.learned = 1'b1;
			end
		end
		// learned route, else flood every used connection but the arrival one
		if (c.dst != shadow.own_address) begin
			if (c.dst != shadow.broadcast_address && c.dst >= 1 && c.dst <= NumHosts
					&& host_known[c.dst - 1]) begin
				site = host_site[c.dst - 1];
				if (site[4])
					r.local_target = site[3:0];
				else if (site[3:0] < MaxConn)
					r.conn_mask = 8'(1 << site[3:0]);
			end else begin
				for (int i = 0; i < nconn; i++)
					if (!(c.from_loc == 1'b0 && c.from_idx == i))
						r.conn_mask[i] = 1'b1;
			end
		end
		// local delivery to own address or broadcast from another host
		if (c.dport != 0 && (c.dst == shadow.own_address
				|| (c.dst == shadow.broadcast_address && c.src != shadow.own_address))) begin
			if (c.dport <= MaxPorts && shadow.port_present_mask[c.dport])
				r.local_target = c.dport;
			else
				missing = 1'b1;
		end
		if ((r.conn_mask & c.cfull) != 0)
			full = 1'b1;
		if (r.local_target != 0 && c.lfull[r.local_target])
			full = 1'b1;
		if (full)
			r.route_status = lcr_pkg::ST_RETRY;
		else if (missing)
			r.route_status = lcr_pkg::ST_MISSING;
		else
			r.route_status = lcr_pkg::ST_ROUTED;
		learn_count += r.learned;
		retry_count += (r.route_status == lcr_pkg::ST_RETRY);
		missing_count += (r.route_status == lcr_pkg::ST_MISSING);
	endtask

	// Send one command, with a random idle gap, and record its expected route
	task automatic send_command(input cmd_t c);
		int                  gap;
		lcr_pkg::route_res_t want;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		src_addr <= c.src;
		dest_addr <= c.dst;
		dest_port <= c.dport;
		from_local <= c.from_loc;
		from_index <= c.from_idx;
		conn_full_mask <= c.cfull;
		local_full_mask <= c.lfull;
		do @(posedge clk); while (!in_ready);
		route_command(c, want);
		route_expect.push_back(want);
		commands_sent++;
	endtask

	// Drop valid and wait until every expected route has come back
	task automatic hold_input();
		@(negedge clk);
		in_valid <= 1'b0;
		while (route_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(int'(idx) * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_OWN_ADDR:   shadow.own_address = value[7:0];
			REG_BCAST_ADDR: shadow.broadcast_address = value[7:0];
			REG_CONN_COUNT: shadow.connection_count = value[3:0];
			REG_PORT_MASK:  shadow.port_present_mask = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reconfigure only once the pipeline has emptied
	task automatic apply_config(input logic [7:0] own, input logic [7:0] bcast,
			input logic [3:0] conns, input logic [15:0] ports);
		hold_input();
		repeat (3) @(posedge clk);
		write_register(REG_OWN_ADDR, 32'(own));
		write_register(REG_BCAST_ADDR, 32'(bcast));
		write_register(REG_CONN_COUNT, 32'(conns));
		write_register(REG_PORT_MASK, 32'(ports));
	endtask

	function automatic cmd_t make_cmd(input logic [7:0] src, input logic [7:0] dst,
			input logic [3:0] dport, input logic from_loc, input logic [3:0] from_idx,
			input logic [7:0] cfull, input logic [15:0] lfull);
		make_cmd = '{src, dst, dport, from_loc, from_idx, cfull, lfull};
	endfunction

	// Random header, biased towards table hosts and the configured addresses
	function automatic cmd_t random_cmd();
		cmd_t c;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: c.src = 8'($urandom_range(NumHosts, 1));
			5:             c.src = shadow.own_address;
			6:             c.src = 8'd0;
			7:             c.src = 8'($urandom_range(255, NumHosts + 1));
			default:       c.src = 8'($urandom());
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3: c.dst = 8'($urandom_range(NumHosts, 1));
			4:          c.dst = shadow.own_address;
			5:          c.dst = shadow.broadcast_address;
			6:          c.dst = 8'd0;
			default:    c.dst = 8'($urandom());
		endcase
		c.dport = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15));
		c.from_loc = 1'($urandom_range(1));
		if ($urandom_range(3) == 0)
			c.from_idx = 4'($urandom_range(15));
		else
			c.from_idx = c.from_loc ? 4'($urandom_range(15, 1)) : 4'($urandom_range(7));
		c.cfull = ($urandom_range(2) == 0) ? 8'($urandom()) : 8'h00;
		c.lfull = ($urandom_range(2) == 0) ? 16'($urandom()) : 16'h0000;
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Compare each result transaction with the oldest expected route
	always @(posedge clk) begin
		lcr_pkg::route_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (route_expect.size() == 0) begin
				report_mismatch("result with nothing expected", 16'(conn_mask), 16'h0);
			end else begin
				want = route_expect.pop_front();
				if (conn_mask !== want.conn_mask)
					report_mismatch("conn_mask", 16'(conn_mask), 16'(want.conn_mask));
				if (local_target !== want.local_target)
					report_mismatch("local_target", 16'(local_target), 16'(want.local_target));
				if (route_status !== want.route_status)
					report_mismatch("route_status", 16'(route_status), 16'(want.route_status));
				if (learned !== want.learned)
					report_mismatch("learned", 16'(learned), 16'(want.learned));
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Timeout: no transaction for %0d cycles", QuietLimit);
			$display("Mismatches found");
			$finish;
		end
	end

	// Hand-picked headers: learning rules, route choice, local delivery, status
	task automatic test_directed_cases();
		sender_idle_pct = 0;
		stall_pct = 0;
		// reset settings: no connections, no local ports
		send_command(make_cmd(8'd3, 8'd255, 4'd2, 1'b0, 4'd0, 8'h00, 16'h0000));
		apply_config(8'd1, 8'd255, 4'd4, 16'h00A4);
		send_command(make_cmd(8'd0, 8'd255, 4'd0, 1'b0, 4'd0, 8'h00, 16'h0000));
		send_command(make_cmd(8'd5, 8'd255, 4'd2, 1'b0, 4'd2, 8'h00, 16'h0000));
		send_command(make_cmd(8'd6, 8'd5, 4'd0, 1'b1, 4'd3, 8'h00, 16'h0000));
		send_command(make_cmd(8'd7, 8'd6, 4'd0, 1'b0, 4'd1, 8'h00, 16'h0008));
		send_command(make_cmd(8'd40, 8'd1, 4'd5, 1'b0, 4'd3, 8'h00, 16'h0000));
		send_command(make_cmd(8'd40, 8'd1, 4'd3, 1'b0, 4'd3, 8'h00, 16'h0000));
		send_command(make_cmd(8'd40, 8'd1, 4'd0, 1'b0, 4'd3, 8'hFF, 16'hFFFF));
		send_command(make_cmd(8'd1, 8'd255, 4'd7, 1'b1, 4'd7, 8'h00, 16'h0000));
		send_command(make_cmd(8'd33, 8'd200, 4'd0, 1'b0, 4'd0, 8'h00, 16'h0000));
		send_command(make_cmd(8'd8, 8'd0, 4'd0, 1'b0, 4'd4, 8'h00, 16'h0000));
		send_command(make_cmd(8'd8, 8'd9, 4'd0, 1'b1, 4'd0, 8'h00, 16'h0000));
		// learn a host and route to it on the very next command
		send_command(make_cmd(8'd9, 8'd255, 4'd0, 1'b0, 4'd3, 8'h01, 16'h0000));
		send_command(make_cmd(8'd10, 8'd9, 4'd0, 1'b0, 4'd0, 8'h00, 16'h0000));
		// missing local port, alone and together with a full queue
		send_command(make_cmd(8'd11, 8'd255, 4'd3, 1'b0, 4'd1, 8'h00, 16'h0000));
		send_command(make_cmd(8'd12, 8'd255, 4'd3, 1'b0, 4'd1, 8'h08, 16'h0000));
		send_command(make_cmd(8'd255, 8'd255, 4'd15, 1'b1, 4'd15, 8'hFF, 16'hFFFF));
		send_command(make_cmd(8'd0, 8'd0, 4'd0, 1'b0, 4'd0, 8'h00, 16'h0000));
		send_command(make_cmd(8'd32, 8'd32, 4'd7, 1'b1, 4'd15, 8'h00, 16'h0080));
		send_command(make_cmd(8'd13, 8'd1, 4'd7, 1'b0, 4'd2, 8'h00, 16'h0080));
	endtask

	// Learn a host, then address it straight after, back to back
	task automatic test_learn_then_route();
		logic       loc;
		logic [3:0] idx;
		sender_idle_pct = 0;
		stall_pct = 0;
		for (int h = 14; h <= 31; h++) begin
			loc = 1'($urandom_range(1));
			idx = loc ? 4'($urandom_range(15, 1)) : 4'($urandom_range(3));
			send_command(make_cmd(8'(h), 8'd255, 4'($urandom_range(15)), loc, idx,
				8'($urandom()), 16'($urandom())));
			send_command(make_cmd(8'($urandom_range(255, 33)), 8'(h), 4'($urandom_range(15)),
				1'($urandom_range(1)), 4'($urandom_range(15)), 8'h00, 16'h0000));
		end
	endtask

	// Random headers over several settings, idling and stalling phases
	task automatic test_random_traffic();
		logic [7:0]  own_tab   [5] = '{8'd1, 8'd200, 8'd32, 8'd255, 8'd0};
		logic [7:0]  bcast_tab [5] = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
		logic [3:0]  conn_tab  [5] = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd0};
		logic [15:0] port_tab  [5] = '{16'hFFFF, 16'h5A3C, 16'h0000, 16'hFFFE, 16'h0};
		int          idle_tab  [5] = '{0, 80, 0, 24, 0};
		int          stall_tab [5] = '{0, 0, 80, 24, 0};
		for (int p = 0; p < 5; p++) begin
			if (p == 4) begin
				own_tab[p] = 8'($urandom_range(255, 1));
				bcast_tab[p] = 8'($urandom());
				conn_tab[p] = 4'($urandom());
				port_tab[p] = 16'($urandom());
			end
			apply_config(own_tab[p], bcast_tab[p], conn_tab[p], port_tab[p]);
			sender_idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			for (int n = 0; n < 90; n++) begin
				// pause the sender until the pipeline is empty, once
				if (p == 1 && n == 45)
					hold_input();
				send_command(random_cmd());
			end
		end
	endtask

	initial begin
		shadow.own_address = lcr_pkg::OwnAddressRst;
		shadow.broadcast_address = lcr_pkg::BroadcastAddrRst;
		shadow.connection_count = lcr_pkg::ConnectionCountRst;
		shadow.port_present_mask = lcr_pkg::PortPresentRst;
		for (int h = 0; h < NumHosts; h++) begin
			host_known[h] = 1'b0;
			host_site[h] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_learn_then_route();
		test_random_traffic();

		hold_input();
		repeat (4) @(posedge clk);
		$display("Sent %0d commands over seven settings, checked %0d routes", commands_sent,
			results_seen);
		$display("Routes that learned a host: %0d, retried: %0d, missing port: %0d",
			learn_count, retry_count, missing_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/lcr_pkg.sv
hw/rtl/lcr_regs.sv
hw/rtl/lcr_table.sv
hw/rtl/lcr_decide.sv
hw/rtl/learning_command_router_top.sv
verif/testbench.sv
